// ===== hw/rtl/rsc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rsc_pkg: shared types and constants of the RPN stack calculator
// Command codes, error masks and the controller/datapath command and status.
// ----------------------------------------------------------------------------
package rsc_pkg;

  localparam int STACK_DEPTH = 128;
  localparam int DATA_W      = 32;
  localparam int MODE_W      = 4;
  localparam int ERR_W       = 5;
  localparam int POPS_W      = 2;
  localparam int DEPTH_OUT_W = 8;

  localparam logic [MODE_W-1:0] MODE_PUSH     = 4'd0;
  localparam logic [MODE_W-1:0] MODE_ADD      = 4'd1;
  localparam logic [MODE_W-1:0] MODE_SUB      = 4'd2;
  localparam logic [MODE_W-1:0] MODE_MUL      = 4'd3;
  localparam logic [MODE_W-1:0] MODE_DIV      = 4'd4;
  localparam logic [MODE_W-1:0] MODE_MOD      = 4'd5;
  localparam logic [MODE_W-1:0] MODE_PRINT    = 4'd6;
  localparam logic [MODE_W-1:0] MODE_DUP      = 4'd7;
  localparam logic [MODE_W-1:0] MODE_SWAP     = 4'd8;
  localparam logic [MODE_W-1:0] MODE_CLEAR    = 4'd9;
  localparam logic [MODE_W-1:0] MODE_POPPRINT = 4'd10;

  localparam logic [ERR_W-1:0] ERR_NONE    = 5'b00000;
  localparam logic [ERR_W-1:0] ERR_EMPTY   = 5'b00001;
  localparam logic [ERR_W-1:0] ERR_FULL    = 5'b00010;
  localparam logic [ERR_W-1:0] ERR_ZDIV    = 5'b00100;
  localparam logic [ERR_W-1:0] ERR_SWAP    = 5'b01000;
  localparam logic [ERR_W-1:0] ERR_UNKNOWN = 5'b10000;

  localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;

  typedef enum logic [1:0] {
    SRC_OPERAND = 2'd0,
    SRC_B       = 2'd1,
    SRC_RES     = 2'd2
  } push_src_t;

  typedef enum logic {
    RD_TOP  = 1'b0,
    RD_NEXT = 1'b1
  } rd_sel_t;

  typedef struct packed {
    logic             latch;
    logic             pop;
    logic             peek;
    rd_sel_t          rd_sel;
    logic             cap_b;
    logic             cap_a;
    logic             show;
    logic             exec;
    logic             mul_fin;
    logic             div_start;
    logic             div_take;
    logic             push;
    push_src_t        push_src;
    logic             swap_w1;
    logic             swap_w2;
    logic             clear;
    logic [ERR_W-1:0] set_err;
    logic             load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              cnt_zero;
    logic              cnt_ge2;
    logic              cap_zero;
    logic              div_done;
    logic              out_free;
  } dp_stat_t;

endpackage
`default_nettype wire

// ===== hw/rtl/rsc_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rsc_if: command and result channels
// Valid/ready channels; a transaction completes when valid and ready are high.
// ----------------------------------------------------------------------------
interface rsc_in_if;
  logic                                     valid;
  logic                                     ready;
  logic        [rsc_pkg::MODE_W-1:0]        mode;
  logic signed [rsc_pkg::DATA_W-1:0]        operand;
  modport source (output valid, mode, operand, input ready);
  modport sink   (input valid, mode, operand, output ready);
endinterface

interface rsc_out_if;
  logic                                     valid;
  logic                                     ready;
  logic signed [rsc_pkg::DATA_W-1:0]        shown_value;
  logic                                     shown_valid;
  logic        [rsc_pkg::ERR_W-1:0]         error_flags;
  logic        [rsc_pkg::POPS_W-1:0]        empty_pops;
  logic        [rsc_pkg::DEPTH_OUT_W-1:0]   stack_depth;
  modport source (output valid, shown_value, shown_valid, error_flags, empty_pops,
                  stack_depth, input ready);
  modport sink   (input valid, shown_value, shown_valid, error_flags, empty_pops,
                  stack_depth, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/rsc_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rsc_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module rsc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/rsc_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rsc_div: iterative Q16.16 divider and remainder unit
// Restoring division on magnitudes, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rsc_div (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                start,
  input  wire logic                                is_mod,
  input  wire logic signed [rsc_pkg::DATA_W-1:0]   dividend,
  input  wire logic signed [rsc_pkg::DATA_W-1:0]   divisor,
  output      logic                                done,
  output      logic signed [rsc_pkg::DATA_W-1:0]   result
);

  localparam int DW    = rsc_pkg::DATA_W;
  localparam int QW    = DW + 16;
  localparam int STEPS = QW;
  localparam int CNTW  = $clog2(STEPS);

  logic            busy_r, busy_nxt;
  logic            done_r, done_nxt;
  logic [CNTW-1:0] cnt_r, cnt_nxt;
  logic [QW-1:0]   dvd_r, dvd_nxt;
  logic [DW-1:0]   rem_r, rem_nxt;
  logic [DW-1:0]   dsr_r, dsr_nxt;
  logic            neg_r, neg_nxt;
  logic            aneg_r, aneg_nxt;
  logic            mod_r, mod_nxt;

  logic [DW-1:0]   ua, ub;
  logic [DW:0]     rem_sh;
  logic            ge;

  always_comb begin
    ua     = dividend[DW-1] ? (~dividend + 1'b1) : dividend;
    ub     = divisor[DW-1]  ? (~divisor + 1'b1)  : divisor;
    rem_sh = {rem_r, dvd_r[QW-1]};
    ge     = rem_sh >= {1'b0, dsr_r};

    busy_nxt = busy_r;
    done_nxt = done_r;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    neg_nxt  = neg_r;
    aneg_nxt = aneg_r;
    mod_nxt  = mod_r;

    if (start) begin
      busy_nxt = 1'b1;
      done_nxt = 1'b0;
      cnt_nxt  = CNTW'(STEPS - 1);
      dvd_nxt  = is_mod ? {16'd0, ua} : {ua, 16'd0};
      rem_nxt  = '0;
      dsr_nxt  = ub;
      neg_nxt  = dividend[DW-1] ^ divisor[DW-1];
      aneg_nxt = dividend[DW-1];
      mod_nxt  = is_mod;
    end else if (busy_r) begin
      // shift one dividend bit into the partial remainder, subtract if it fits
      rem_nxt = ge ? DW'(rem_sh - {1'b0, dsr_r}) : rem_sh[DW-1:0];
      dvd_nxt = {dvd_r[QW-2:0], ge};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r  <= cnt_nxt;
    dvd_r  <= dvd_nxt;
    rem_r  <= rem_nxt;
    dsr_r  <= dsr_nxt;
    neg_r  <= neg_nxt;
    aneg_r <= aneg_nxt;
    mod_r  <= mod_nxt;
  end

  always_comb begin
    if (mod_r) begin
      result = aneg_r ? (~rem_r + 1'b1) : rem_r;
    end else if (!neg_r) begin
      result = (|dvd_r[QW-1:DW-1]) ? rsc_pkg::VAL_MAX : {1'b0, dvd_r[DW-2:0]};
    end else if (dvd_r > QW'(rsc_pkg::VAL_MAX) + 1'b1) begin
      result = rsc_pkg::VAL_MIN;
    end else begin
      result = ~dvd_r[DW-1:0] + 1'b1;
    end
  end

  assign done = done_r;

endmodule
`default_nettype wire

// ===== hw/rtl/rsc_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rsc_datapath: stack storage, operand registers and arithmetic
// Executes controller commands; holds the result register.
// ----------------------------------------------------------------------------
module rsc_datapath #(
  parameter int STACK_DEPTH = rsc_pkg::STACK_DEPTH
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire rsc_pkg::dp_cmd_t                       cmd,
  output      rsc_pkg::dp_stat_t                      stat,
  input  wire logic        [rsc_pkg::MODE_W-1:0]      in_mode,
  input  wire logic signed [rsc_pkg::DATA_W-1:0]      in_operand,
  output      logic                                   out_valid,
  input  wire logic                                   out_ready,
  output      logic signed [rsc_pkg::DATA_W-1:0]      out_shown_value,
  output      logic                                   out_shown_valid,
  output      logic        [rsc_pkg::ERR_W-1:0]       out_error_flags,
  output      logic        [rsc_pkg::POPS_W-1:0]      out_empty_pops,
  output      logic        [rsc_pkg::DEPTH_OUT_W-1:0] out_stack_depth
);

  localparam int DW = rsc_pkg::DATA_W;
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int AW = $clog2(STACK_DEPTH);

  logic        [rsc_pkg::MODE_W-1:0] mode_r, mode_nxt;
  logic signed [DW-1:0]              operand_r, operand_nxt;
  logic        [CW-1:0]              count_r, count_nxt;
  logic        [rsc_pkg::ERR_W-1:0]  err_r, err_nxt;
  logic        [rsc_pkg::POPS_W-1:0] pops_r, pops_nxt;
  logic signed [DW-1:0]              shown_r, shown_nxt;
  logic                              valid_r, valid_nxt;
  logic signed [DW-1:0]              b_r, b_nxt;
  logic signed [DW-1:0]              a_r, a_nxt;
  logic signed [DW-1:0]              res_r, res_nxt;
  logic signed [2*DW-1:0]            prod_r, prod_nxt;
  logic                              rd_pend_r, rd_pend_nxt;
  logic                              ovalid_r, ovalid_nxt;
  logic signed [DW-1:0]              oshown_r;
  logic                              oshv_r;
  logic        [rsc_pkg::ERR_W-1:0]  oerr_r;
  logic        [rsc_pkg::POPS_W-1:0] opops_r;
  logic        [CW-1:0]              ocount_r;

  logic                              ram_we, ram_re;
  logic        [AW-1:0]              ram_waddr, ram_raddr;
  logic        [DW-1:0]              ram_wdata, ram_rdata;

  logic        [CW-1:0]              cnt_m1, cnt_m2;
  logic        [AW-1:0]              addr_top, addr_next, addr_push;
  logic                              cnt_zero, full;
  logic signed [DW-1:0]              cap_val;
  logic signed [DW:0]                sum_w, dif_w;
  logic signed [DW-1:0]              sum_sat, dif_sat, mul_sat;
  logic signed [2*DW-1:0]            prod_sh;
  logic                              div_done;
  logic signed [DW-1:0]              div_res;
  logic        [CW+rsc_pkg::DEPTH_OUT_W-1:0] depth_ext;

  rsc_ram #(.WIDTH(DW), .DEPTH(STACK_DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  rsc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .is_mod   (mode_r == rsc_pkg::MODE_MOD),
    .dividend (a_r),
    .divisor  (b_r),
    .done     (div_done),
    .result   (div_res)
  );

  always_comb begin
    cnt_m1    = count_r - 1'b1;
    cnt_m2    = count_r - CW'(2);
    addr_top  = cnt_m1[AW-1:0];
    addr_next = cnt_m2[AW-1:0];
    addr_push = count_r[AW-1:0];
    cnt_zero  = count_r == '0;
    full      = count_r == CW'(STACK_DEPTH);
    cap_val   = rd_pend_r ? ram_rdata : '0;

    sum_w   = {a_r[DW-1], a_r} + {b_r[DW-1], b_r};
    dif_w   = {a_r[DW-1], a_r} - {b_r[DW-1], b_r};
    sum_sat = (sum_w[DW] != sum_w[DW-1]) ?
              (sum_w[DW] ? rsc_pkg::VAL_MIN : rsc_pkg::VAL_MAX) : sum_w[DW-1:0];
    dif_sat = (dif_w[DW] != dif_w[DW-1]) ?
              (dif_w[DW] ? rsc_pkg::VAL_MIN : rsc_pkg::VAL_MAX) : dif_w[DW-1:0];
    // arithmetic shift floors, matching round toward minus infinity
    prod_sh = prod_r >>> 16;
    if (prod_sh > 64'(rsc_pkg::VAL_MAX)) begin
      mul_sat = rsc_pkg::VAL_MAX;
    end else if (prod_sh < 64'(rsc_pkg::VAL_MIN)) begin
      mul_sat = rsc_pkg::VAL_MIN;
    end else begin
      mul_sat = prod_sh[DW-1:0];
    end
  end

  always_comb begin
    mode_nxt    = mode_r;
    operand_nxt = operand_r;
    count_nxt   = count_r;
    err_nxt     = err_r | cmd.set_err;
    pops_nxt    = pops_r;
    shown_nxt   = shown_r;
    valid_nxt   = valid_r;
    b_nxt       = b_r;
    a_nxt       = a_r;
    res_nxt     = res_r;
    prod_nxt    = prod_r;
    rd_pend_nxt = rd_pend_r;
    ovalid_nxt  = ovalid_r && !out_ready;
    ram_re      = 1'b0;
    ram_raddr   = addr_top;
    ram_we      = 1'b0;
    ram_waddr   = addr_push;
    ram_wdata   = res_r;

    if (cmd.latch) begin
      mode_nxt    = in_mode;
      operand_nxt = in_operand;
      err_nxt     = rsc_pkg::ERR_NONE;
      pops_nxt    = '0;
      shown_nxt   = '0;
      valid_nxt   = 1'b0;
    end

    if (cmd.pop) begin
      rd_pend_nxt = !cnt_zero;
      if (cnt_zero) begin
        err_nxt  = err_nxt | rsc_pkg::ERR_EMPTY;
        pops_nxt = pops_r + 1'b1;
      end else begin
        ram_re    = 1'b1;
        count_nxt = cnt_m1;
      end
    end

    if (cmd.peek) begin
      ram_re      = 1'b1;
      rd_pend_nxt = 1'b1;
      ram_raddr   = (cmd.rd_sel == rsc_pkg::RD_NEXT) ? addr_next : addr_top;
    end

    if (cmd.cap_b) begin
      b_nxt = cap_val;
    end
    if (cmd.cap_a) begin
      a_nxt = cap_val;
    end
    if (cmd.show) begin
      shown_nxt = cap_val;
      valid_nxt = 1'b1;
    end

    if (cmd.exec) begin
      case (mode_r)
        rsc_pkg::MODE_ADD: res_nxt  = sum_sat;
        rsc_pkg::MODE_SUB: res_nxt  = dif_sat;
        default:           prod_nxt = a_r * b_r;
      endcase
    end
    if (cmd.mul_fin) begin
      res_nxt = mul_sat;
    end
    if (cmd.div_take) begin
      res_nxt = div_res;
    end

    if (cmd.push) begin
      if (full) begin
        err_nxt = err_nxt | rsc_pkg::ERR_FULL;
      end else begin
        ram_we    = 1'b1;
        count_nxt = count_r + 1'b1;
        case (cmd.push_src)
          rsc_pkg::SRC_OPERAND: ram_wdata = operand_r;
          rsc_pkg::SRC_B:       ram_wdata = b_r;
          default:              ram_wdata = res_r;
        endcase
      end
    end

    // swap writes: old second entry to the top, old top below it
    if (cmd.swap_w1) begin
      ram_we    = 1'b1;
      ram_waddr = addr_top;
      ram_wdata = a_r;
    end
    if (cmd.swap_w2) begin
      ram_we    = 1'b1;
      ram_waddr = addr_next;
      ram_wdata = b_r;
    end

    if (cmd.clear) begin
      count_nxt = '0;
    end

    if (cmd.load_out) begin
      ovalid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      rd_pend_r <= 1'b0;
      ovalid_r  <= 1'b0;
      err_r     <= rsc_pkg::ERR_NONE;
      pops_r    <= '0;
    end else begin
      count_r   <= count_nxt;
      rd_pend_r <= rd_pend_nxt;
      ovalid_r  <= ovalid_nxt;
      err_r     <= err_nxt;
      pops_r    <= pops_nxt;
    end
    mode_r    <= mode_nxt;
    operand_r <= operand_nxt;
    shown_r   <= shown_nxt;
    valid_r   <= valid_nxt;
    b_r       <= b_nxt;
    a_r       <= a_nxt;
    res_r     <= res_nxt;
    prod_r    <= prod_nxt;
    if (cmd.load_out) begin
      oshown_r <= shown_r;
      oshv_r   <= valid_r;
      oerr_r   <= err_r;
      opops_r  <= pops_r;
      ocount_r <= count_r;
    end
  end

  always_comb begin
    stat.mode     = mode_r;
    stat.cnt_zero = cnt_zero;
    stat.cnt_ge2  = count_r >= CW'(2);
    stat.cap_zero = cap_val == '0;
    stat.div_done = div_done;
    stat.out_free = !ovalid_r || out_ready;
  end

  assign depth_ext       = {{rsc_pkg::DEPTH_OUT_W{1'b0}}, ocount_r};
  assign out_valid       = ovalid_r;
  assign out_shown_value = oshown_r;
  assign out_shown_valid = oshv_r;
  assign out_error_flags = oerr_r;
  assign out_empty_pops  = opops_r;
  assign out_stack_depth = depth_ext[rsc_pkg::DEPTH_OUT_W-1:0];

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(STACK_DEPTH))
    else $error("stack count beyond depth");

  a_full_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.push && full) |-> !ram_we)
    else $error("write issued on full stack");

  a_pops_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pops_r <= 2'd2)
    else $error("more than two empty pops");

  a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |=> ovalid_r)
    else $error("result load lost");

endmodule
`default_nettype wire

// ===== hw/rtl/rsc_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rsc_ctrl: command sequencer of the RPN stack calculator
// Walks each command through pops, arithmetic, push and result load.
// ----------------------------------------------------------------------------
module rsc_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output      logic              in_ready,
  input  wire rsc_pkg::dp_stat_t stat,
  output      rsc_pkg::dp_cmd_t  cmd
);

  typedef enum logic [14:0] {
    S_IDLE     = 15'h0001,
    S_DECODE   = 15'h0002,
    S_CAP_B    = 15'h0004,
    S_POP_A    = 15'h0008,
    S_CAP_A    = 15'h0010,
    S_EXEC     = 15'h0020,
    S_MUL_FIN  = 15'h0040,
    S_DIV_GO   = 15'h0080,
    S_DIV_WAIT = 15'h0100,
    S_PUSH     = 15'h0200,
    S_SW_B     = 15'h0400,
    S_SW_A     = 15'h0800,
    S_SW_W1    = 15'h1000,
    S_SW_W2    = 15'h2000,
    S_RESP     = 15'h4000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;

    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        case (stat.mode)
          rsc_pkg::MODE_PUSH: begin
            state_nxt = S_PUSH;
          end
          rsc_pkg::MODE_ADD, rsc_pkg::MODE_SUB, rsc_pkg::MODE_MUL,
          rsc_pkg::MODE_DIV, rsc_pkg::MODE_MOD, rsc_pkg::MODE_POPPRINT: begin
            cmd.pop   = 1'b1;
            state_nxt = S_CAP_B;
          end
          rsc_pkg::MODE_PRINT, rsc_pkg::MODE_DUP: begin
            if (stat.cnt_zero) begin
              cmd.set_err = rsc_pkg::ERR_EMPTY;
              state_nxt   = S_RESP;
            end else begin
              cmd.peek  = 1'b1;
              state_nxt = S_CAP_B;
            end
          end
          rsc_pkg::MODE_SWAP: begin
            if (!stat.cnt_ge2) begin
              cmd.set_err = rsc_pkg::ERR_SWAP;
              state_nxt   = S_RESP;
            end else begin
              cmd.peek  = 1'b1;
              state_nxt = S_SW_B;
            end
          end
          rsc_pkg::MODE_CLEAR: begin
            cmd.clear = 1'b1;
            state_nxt = S_RESP;
          end
          default: begin
            cmd.set_err = rsc_pkg::ERR_UNKNOWN;
            state_nxt   = S_RESP;
          end
        endcase
      end
      S_CAP_B: begin
        cmd.cap_b = 1'b1;
        case (stat.mode)
          rsc_pkg::MODE_DIV, rsc_pkg::MODE_MOD: begin
            if (stat.cap_zero) begin
              cmd.set_err = rsc_pkg::ERR_ZDIV;
              state_nxt   = S_RESP;
            end else begin
              state_nxt = S_POP_A;
            end
          end
          rsc_pkg::MODE_PRINT, rsc_pkg::MODE_POPPRINT: begin
            cmd.show  = 1'b1;
            state_nxt = S_RESP;
          end
          rsc_pkg::MODE_DUP: begin
            cmd.show  = 1'b1;
            state_nxt = S_PUSH;
          end
          default: begin
            state_nxt = S_POP_A;
          end
        endcase
      end
      S_POP_A: begin
        cmd.pop   = 1'b1;
        state_nxt = S_CAP_A;
      end
      S_CAP_A: begin
        cmd.cap_a = 1'b1;
        if (stat.mode == rsc_pkg::MODE_DIV || stat.mode == rsc_pkg::MODE_MOD) begin
          state_nxt = S_DIV_GO;
        end else begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = (stat.mode == rsc_pkg::MODE_MUL) ? S_MUL_FIN : S_PUSH;
      end
      S_MUL_FIN: begin
        cmd.mul_fin = 1'b1;
        state_nxt   = S_PUSH;
      end
      S_DIV_GO: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (stat.div_done) begin
          cmd.div_take = 1'b1;
          state_nxt    = S_PUSH;
        end
      end
      S_PUSH: begin
        cmd.push = 1'b1;
        case (stat.mode)
          rsc_pkg::MODE_PUSH: cmd.push_src = rsc_pkg::SRC_OPERAND;
          rsc_pkg::MODE_DUP:  cmd.push_src = rsc_pkg::SRC_B;
          default:            cmd.push_src = rsc_pkg::SRC_RES;
        endcase
        state_nxt = S_RESP;
      end
      S_SW_B: begin
        cmd.cap_b  = 1'b1;
        cmd.peek   = 1'b1;
        cmd.rd_sel = rsc_pkg::RD_NEXT;
        state_nxt  = S_SW_A;
      end
      S_SW_A: begin
        cmd.cap_a = 1'b1;
        state_nxt = S_SW_W1;
      end
      S_SW_W1: begin
        cmd.swap_w1 = 1'b1;
        state_nxt   = S_SW_W2;
      end
      S_SW_W2: begin
        cmd.swap_w2 = 1'b1;
        state_nxt   = S_RESP;
      end
      S_RESP: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/rpn_stack_calculator_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rpn_stack_calculator_top: reverse-Polish stack calculator, Q16.16
// Takes one parsed command per transaction and returns one result per command.
// ----------------------------------------------------------------------------
// Each command transaction on in_ch returns exactly one result transaction on
// out_ch, in order. Values are signed Q16.16; add, subtract and multiply
// saturate, divide truncates toward zero and saturates, remainder takes the
// sign of the dividend. The stack lives in a RAM of STACK_DEPTH words with one
// registered read port, so each stack read is captured in a register before
// it is used. Divide and remainder run through a 48-step restoring divider.
// A new command is taken once the previous one has been placed in the output
// register; that register holds the result until out_ch takes it, so the
// block keeps working while a result waits. The stack needs no clearing after
// reset: only entries below the stack count are ever read. stack_depth reports
// the low 8 bits of the count.
// ----------------------------------------------------------------------------
module rpn_stack_calculator_top #(
  parameter int STACK_DEPTH = rsc_pkg::STACK_DEPTH
) (
  input wire logic   clk,
  input wire logic   rst_n,
  rsc_in_if.sink     in_ch,
  rsc_out_if.source  out_ch
);

  rsc_pkg::dp_cmd_t  cmd;
  rsc_pkg::dp_stat_t stat;
  logic              in_ready;

  // sequence each command
  rsc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // stack, arithmetic and result register
  rsc_datapath #(.STACK_DEPTH(STACK_DEPTH)) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_mode         (in_ch.mode),
    .in_operand      (in_ch.operand),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_shown_value (out_ch.shown_value),
    .out_shown_valid (out_ch.shown_valid),
    .out_error_flags (out_ch.error_flags),
    .out_empty_pops  (out_ch.empty_pops),
    .out_stack_depth (out_ch.stack_depth)
  );

  assign in_ch.ready = in_ready;

endmodule
`default_nettype wire

// ===== dv/rsc_tb_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsc_tb_if: testbench-side note on channels
// The channel interfaces come with the RTL (rsc_if.sv); this file only adds
// a small helper interface that carries the long receiver hold-off request.
// ----------------------------------------------------------------------------
interface rsc_hold_if;
  logic       request;
  int         cycles;
  modport source (output request, cycles);
  modport sink   (input request, cycles);
endinterface

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: RPN stack calculator checker
// Drives parsed commands, predicts each result with a local stack model and
// compares every result field; random stalls on both channels.
// ----------------------------------------------------------------------------
module testbench;
  import rsc_pkg::*;

  typedef struct packed {
    logic signed [31:0] shown_value;
    logic               shown_valid;
    logic [4:0]         error_flags;
    logic [1:0]         empty_pops;
    logic [7:0]         stack_depth;
  } calc_result_t;

  localparam logic [MODE_W-1:0] MODE_UNKNOWN = 4'd11;
  localparam logic [MODE_W-1:0] MODE_LAST    = 4'd15;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #1 clk = ~clk;

  rsc_in_if  in_ch ();
  rsc_out_if out_ch ();
  rsc_hold_if hold ();

  rpn_stack_calculator_top dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  // Local copy of the stack state
  logic signed [31:0] calc_stack [STACK_DEPTH];
  int unsigned        calc_count;
  calc_result_t       pending_results [$];
  int                 mismatches;
  bit                 idle_on;

  logic [4:0]  step_flags;
  logic [1:0]  step_pops;

  function automatic logic signed [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return VAL_MAX;
    if (v < -64'sd2147483648) return VAL_MIN;
    return v[31:0];
  endfunction

  function automatic void stack_push(logic signed [31:0] v);
    if (calc_count < STACK_DEPTH) begin
      calc_stack[calc_count] = v;
      calc_count++;
    end else begin
      step_flags |= ERR_FULL;
    end
  endfunction

  function automatic logic signed [31:0] stack_pop();
    if (calc_count > 0) begin
      calc_count--;
      return calc_stack[calc_count];
    end
    step_flags |= ERR_EMPTY;
    step_pops++;
    return 0;
  endfunction

  function automatic logic signed [31:0] q16_mul(logic signed [31:0] a, logic signed [31:0] b);
    longint p;
    longint q;
    p = longint'(a) * longint'(b);
    q = p >>> 16;  // arithmetic shift rounds toward minus infinity
    return clamp32(q);
  endfunction

  // Work out the result of one command and advance the stack model
  function automatic calc_result_t calc_command(logic [3:0] mode, logic signed [31:0] operand);
    calc_result_t r;
    logic signed [31:0] a, b;
    r = '0;
    step_flags = ERR_NONE;
    step_pops = 0;
    case (mode)
      MODE_PUSH: stack_push(operand);
      MODE_ADD: begin
        b = stack_pop(); a = stack_pop();
        stack_push(clamp32(longint'(a) + longint'(b)));
      end
      MODE_SUB: begin
        b = stack_pop(); a = stack_pop();
        stack_push(clamp32(longint'(a) - longint'(b)));
      end
      MODE_MUL: begin
        b = stack_pop(); a = stack_pop();
        stack_push(q16_mul(a, b));
      end
      MODE_DIV, MODE_MOD: begin
        b = stack_pop();
        if (b != 0) begin
          a = stack_pop();
          if (mode == MODE_DIV) stack_push(clamp32((longint'(a) * 65536) / longint'(b)));
          else stack_push(32'(longint'(a) % longint'(b)));
        end else begin
          step_flags |= ERR_ZDIV;
        end
      end
      MODE_PRINT: begin
        if (calc_count > 0) begin
          r.shown_value = calc_stack[calc_count-1];
          r.shown_valid = 1'b1;
        end else begin
          step_flags |= ERR_EMPTY;
        end
      end
      MODE_DUP: begin
        if (calc_count > 0) begin
          r.shown_value = calc_stack[calc_count-1];
          r.shown_valid = 1'b1;
          stack_push(r.shown_value);
        end else begin
          step_flags |= ERR_EMPTY;
        end
      end
      MODE_SWAP: begin
        if (calc_count >= 2) begin
          a = calc_stack[calc_count-1];
          calc_stack[calc_count-1] = calc_stack[calc_count-2];
          calc_stack[calc_count-2] = a;
        end else begin
          step_flags |= ERR_SWAP;
        end
      end
      MODE_CLEAR: calc_count = 0;
      MODE_POPPRINT: begin
        r.shown_value = stack_pop();
        r.shown_valid = 1'b1;
      end
      default: step_flags |= ERR_UNKNOWN;
    endcase
    r.error_flags = step_flags;
    r.empty_pops = step_pops;
    r.stack_depth = calc_count[7:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  // Send one command; hold valid across back-to-back transactions
  task automatic send_command(logic [3:0] mode, logic signed [31:0] operand);
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 8);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.mode    <= mode;
    in_ch.operand <= operand;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pending_results.push_back(calc_command(mode, operand));
  endtask

  task automatic drop_valid();
    in_ch.valid <= 1'b0;
  endtask

  function automatic logic signed [31:0] rand_value();
    case ($urandom_range(0, 5))
      0: return VAL_MAX;
      1: return VAL_MIN;
      2: return 0;
      3: return $signed($urandom_range(0, 32'h3_0000)) - 32'sh1_8000;
      default: return $urandom;
    endcase
  endfunction

  // Receiver: random stalls, one long hold-off per request
  initial begin
    int burst;
    bit held;
    out_ch.ready <= 1'b0;
    held = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold.request !== 1'b1) held = 1'b0;
      if (hold.request === 1'b1 && !held) begin
        held = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (hold.cycles) @(posedge clk);
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        burst = $urandom_range(1, 8);
        out_ch.ready <= 1'b0;
        repeat (burst) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Check each accepted result against the oldest expectation
  always @(posedge clk) begin
    calc_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", out_ch.stack_depth, -1);
      end else begin
        want = pending_results.pop_front();
        if (out_ch.shown_value !== want.shown_value)
          report_mismatch("shown_value", out_ch.shown_value, want.shown_value);
        if (out_ch.shown_valid !== want.shown_valid)
          report_mismatch("shown_valid", out_ch.shown_valid, want.shown_valid);
        if (out_ch.error_flags !== want.error_flags)
          report_mismatch("error_flags", out_ch.error_flags, want.error_flags);
        if (out_ch.empty_pops !== want.empty_pops)
          report_mismatch("empty_pops", out_ch.empty_pops, want.empty_pops);
        if (out_ch.stack_depth !== want.stack_depth)
          report_mismatch("stack_depth", out_ch.stack_depth, want.stack_depth);
      end
    end
  end

  // Directed: every command, empty-stack pops, zero divisors, value extremes
  task automatic test_directed();
    send_command(MODE_POPPRINT, 0);
    send_command(MODE_ADD, 0);
    send_command(MODE_PRINT, 0);
    send_command(MODE_DUP, 0);
    send_command(MODE_SWAP, 0);
    send_command(MODE_DIV, 0);
    send_command(MODE_PUSH, VAL_MAX);
    send_command(MODE_DUP, 0);
    send_command(MODE_ADD, 0);
    send_command(MODE_PUSH, VAL_MIN);
    send_command(MODE_MUL, 0);
    send_command(MODE_PUSH, 32'sh0003_0000);
    send_command(MODE_PUSH, -32'sh0002_0000);
    send_command(MODE_SWAP, 0);
    send_command(MODE_MOD, 0);
    send_command(MODE_PUSH, 0);
    send_command(MODE_MOD, 0);
    send_command(MODE_PUSH, -32'sh0000_0001);
    send_command(MODE_DIV, 0);
    send_command(MODE_PUSH, 32'sh0000_0007);
    send_command(MODE_SUB, 0);
    send_command(MODE_POPPRINT, 0);
    send_command(MODE_UNKNOWN, 0);
    send_command(MODE_LAST, 32'sh5555_AAAA);
    send_command(MODE_CLEAR, 0);
  endtask

  // Start a long receiver hold-off and fill past capacity, then drain
  task automatic test_full_stack();
    hold.cycles  <= 300;
    hold.request <= 1'b1;
    for (int i = 0; i < STACK_DEPTH + 3; i++) send_command(MODE_PUSH, rand_value());
    hold.request <= 1'b0;
    send_command(MODE_DUP, 0);
    send_command(MODE_SWAP, 0);
    send_command(MODE_DIV, 0);
    send_command(MODE_CLEAR, 0);
  endtask

  // Random programs: mostly pushes feeding arithmetic, some noise
  task automatic test_random(int count);
    int pick;
    logic [3:0] mode;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 35 || calc_count < 2 && pick < 60) mode = MODE_PUSH;
      else if (pick < 85) mode = 4'($urandom_range(MODE_ADD, MODE_MOD));
      else if (pick < 97) mode = 4'($urandom_range(MODE_PRINT, MODE_POPPRINT));
      else mode = 4'($urandom_range(MODE_UNKNOWN, MODE_LAST));
      if (mode == MODE_CLEAR && $urandom_range(0, 3) != 0) mode = MODE_PRINT;
      send_command(mode, (mode == MODE_PUSH) ? rand_value() : $signed($urandom));
    end
  endtask

  initial begin
    in_ch.valid   <= 1'b0;
    in_ch.mode    <= MODE_PUSH;
    in_ch.operand <= '0;
    hold.request  <= 1'b0;
    hold.cycles   <= 0;
    calc_count = 0;
    mismatches = 0;
    idle_on = 1'b1;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_full_stack();
    test_random(180);
    // last stretch without idling
    idle_on = 1'b0;
    test_random(60);
    drop_valid();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (mismatches == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

  initial begin
    #400000;
    $display("FAIL");
    $finish;
  end
endmodule
